FILE: src/llq_pkg.sv
`default_nettype none

package llq_pkg;

    localparam int NODES_DEF  = 16;
    localparam int QUEUES_DEF = 4;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_NOT_MEMBER = 2'd2;
    localparam logic [1:0] ST_LINKED     = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] queue_id;
        logic [3:0] node_id;
    } llq_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] count;
        logic [3:0] head_node;
        logic       head_valid;
    } llq_out_t;

endpackage

`default_nettype wire

FILE: src/linked_list_queue_manager_top.sv
// Each command item passes through an input register and a result register.
// Throughput: one item per cycle unless a low m_ready stalls the result; each
// command reads and updates the link, owner, head and count register files in one pass.
// Reset (aresetn low, synchronous) empties both pipeline registers, clears all
// linked bits and queue counts; links, owner tags and heads are left unreset.
`default_nettype none

module linked_list_queue_manager_top import llq_pkg::*; #(
    parameter int NODES  = NODES_DEF,
    parameter int QUEUES = QUEUES_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire llq_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output llq_out_t     m_data
);

    logic     in_valid_reg;
    llq_in_t  in_data_reg;
    logic     out_valid_reg;
    llq_out_t out_data_reg;
    logic     advance;
    llq_out_t core_result;

    // The command in the input register executes when the result register
    // can take its outcome.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    llq_core #(
        .NODES  (NODES),
        .QUEUES (QUEUES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_fire   (advance),
        .op_data   (in_data_reg),
        .op_result (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    a_head_valid_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.head_valid == (out_data_reg.count != 5'd0)))
        else $error("head_valid disagrees with count");

    a_empty_head_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_data_reg.head_valid) |-> (out_data_reg.head_node == 4'd0))
        else $error("empty queue reports a nonzero head");

    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("executed command produced no result item");

    a_held_command_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("stalled command was lost or changed");

endmodule

`default_nettype wire

FILE: src/llq_core.sv
`default_nettype none

module llq_core import llq_pkg::*; #(
    parameter int NODES  = NODES_DEF,
    parameter int QUEUES = QUEUES_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     op_fire,
    input  wire llq_in_t  op_data,
    output llq_out_t      op_result
);

    localparam int NW = $clog2(NODES);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int CW = $clog2(NODES + 1);

    // Links, owner tags and heads are only read behind a linked bit or a
    // nonzero count, so they carry no reset.
    logic [NW-1:0] next_link_reg  [NODES];
    logic [NW-1:0] prev_link_reg  [NODES];
    logic [QW-1:0] node_owner_reg [NODES];
    logic [NW-1:0] queue_head_reg [QUEUES];
    logic [NODES-1:0] node_linked_reg;
    logic [CW-1:0]    queue_count_reg [QUEUES];

    logic [31:0]   n_ext;
    logic [31:0]   q_ext;
    logic          n_ok;
    logic          q_ok;
    logic [NW-1:0] n_idx;
    logic [QW-1:0] q_idx;
    logic [CW-1:0] cnt_q;
    logic          q_empty;
    logic [NW-1:0] h;
    logic [NW-1:0] t;
    logic [NW-1:0] p;
    logic [NW-1:0] x;
    logic          n_linked;
    logic          n_member;
    logic          do_append;
    logic          do_remove;
    logic [1:0]    status;
    logic [CW-1:0] cnt_after;
    logic [NW-1:0] head_after;

    always_comb begin
        n_ext    = 32'(op_data.node_id);
        q_ext    = 32'(op_data.queue_id);
        n_ok     = n_ext < NODES;
        q_ok     = q_ext < QUEUES;
        n_idx    = NW'(n_ext);
        q_idx    = QW'(q_ext);
        cnt_q    = q_ok ? queue_count_reg[q_idx] : '0;
        q_empty  = (cnt_q == '0);
        h        = queue_head_reg[q_idx];
        t        = prev_link_reg[h];
        p        = prev_link_reg[n_idx];
        x        = next_link_reg[n_idx];
        n_linked = n_ok && node_linked_reg[n_idx];
        n_member = n_linked && (node_owner_reg[n_idx] == q_idx);

        do_append = 1'b0;
        do_remove = 1'b0;
        status    = ST_OK;
        unique case (op_data.command)
            CMD_APPEND: begin
                if (!q_ok || n_linked || !n_ok) begin
                    status = ST_LINKED;
                end else begin
                    do_append = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (q_empty) begin
                    status = ST_EMPTY;
                end else if (!n_member) begin
                    status = ST_NOT_MEMBER;
                end else begin
                    do_remove = 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase

        cnt_after  = cnt_q;
        head_after = h;
        if (do_append) begin
            cnt_after = CW'(cnt_q + CW'(1));
            if (q_empty) begin
                head_after = n_idx;
            end
        end else if (do_remove) begin
            cnt_after = CW'(cnt_q - CW'(1));
            if (h == n_idx) begin
                head_after = x;
            end
        end

        op_result.status     = status;
        op_result.count      = 5'(cnt_after);
        op_result.head_valid = (cnt_after != '0);
        op_result.head_node  = (cnt_after != '0) ? 4'(head_after) : 4'd0;
    end

    always_ff @(posedge aclk) begin
        if (op_fire) begin
            if (do_append) begin
                node_owner_reg[n_idx] <= q_idx;
                if (q_empty) begin
                    queue_head_reg[q_idx] <= n_idx;
                    next_link_reg[n_idx]  <= n_idx;
                    prev_link_reg[n_idx]  <= n_idx;
                end else begin
                    // The new node sits between the tail and the head.
                    prev_link_reg[n_idx] <= t;
                    next_link_reg[n_idx] <= h;
                    next_link_reg[t]     <= n_idx;
                    prev_link_reg[h]     <= n_idx;
                end
            end else if (do_remove) begin
                next_link_reg[p] <= x;
                prev_link_reg[x] <= p;
                if (h == n_idx) begin
                    queue_head_reg[q_idx] <= x;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_linked_reg <= '0;
            for (int i = 0; i < QUEUES; i++) begin
                queue_count_reg[i] <= '0;
            end
        end else if (op_fire) begin
            if (do_append) begin
                node_linked_reg[n_idx] <= 1'b1;
                queue_count_reg[q_idx] <= cnt_after;
            end else if (do_remove) begin
                node_linked_reg[n_idx] <= 1'b0;
                queue_count_reg[q_idx] <= cnt_after;
            end
        end
    end

endmodule

`default_nettype wire
